/* design/glls_pkg.sv */
// ----------------------------------------------------------------------------
// glls_pkg: shared types and microprogram of the least-loaded batch scheduler
// The control store holds one control word per step: datapath strobes, a
// jump condition and a jump target.
// ----------------------------------------------------------------------------
package glls_pkg;

   localparam int STEP_W = 4;

   localparam logic [STEP_W-1:0] STEP_CLEAR      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_LOAD       = 4'd1;
   localparam logic [STEP_W-1:0] STEP_JOB_INIT   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_JOB_SCAN   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_JOB_DRAIN  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_NODE_INIT  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_NODE_SCAN  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_NODE_DRAIN = 4'd7;
   localparam logic [STEP_W-1:0] STEP_UPDATE     = 4'd8;
   localparam logic [STEP_W-1:0] STEP_WAIT_OUT   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_EMIT       = 4'd10;
   localparam logic [STEP_W-1:0] STEP_DONE       = 4'd11;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_SCAN_MORE,
      COND_NOT_CLOSE,
      COND_OUT_BUSY,
      COND_MORE_JOBS
   } glls_cond_type;

   // Datapath strobes of one control word.
   typedef struct packed {
      logic accept;
      logic clear_wr;
      logic ptr_clr;
      logic ptr_inc;
      logic lim_job;
      logic lim_node;
      logic rd_job;
      logic rd_node;
      logic best_clr;
      logic mark;
      logic upd;
      logic emit;
      logic done;
   } glls_ctl_type;

   // Datapath status that the jump conditions test.
   typedef struct packed {
      logic scan_more;
      logic close_acc;
      logic out_busy;
      logic more_jobs;
   } glls_stat_type;

   typedef struct packed {
      glls_ctl_type            ctl;
      glls_cond_type           cond;
      logic [STEP_W-1:0]       target;
   } glls_uword_type;

   function automatic glls_uword_type glls_ucode(input logic [STEP_W-1:0] step);
      glls_uword_type w;
      w        = '0;
      w.cond   = COND_NEVER;
      w.target = STEP_LOAD;
      unique case (step)
         STEP_CLEAR: begin
            w.ctl.clear_wr = 1'b1;
            w.ctl.ptr_inc  = 1'b1;
            w.cond         = COND_SCAN_MORE;
            w.target       = STEP_CLEAR;
         end
         STEP_LOAD: begin
            w.ctl.accept = 1'b1;
            w.cond       = COND_NOT_CLOSE;
            w.target     = STEP_LOAD;
         end
         STEP_JOB_INIT: begin
            w.ctl.ptr_clr  = 1'b1;
            w.ctl.lim_job  = 1'b1;
            w.ctl.best_clr = 1'b1;
         end
         STEP_JOB_SCAN: begin
            w.ctl.rd_job  = 1'b1;
            w.ctl.ptr_inc = 1'b1;
            w.cond        = COND_SCAN_MORE;
            w.target      = STEP_JOB_SCAN;
         end
         STEP_JOB_DRAIN: begin
            w.cond = COND_NEVER;
         end
         STEP_NODE_INIT: begin
            w.ctl.mark     = 1'b1;
            w.ctl.ptr_clr  = 1'b1;
            w.ctl.lim_node = 1'b1;
         end
         STEP_NODE_SCAN: begin
            w.ctl.rd_node = 1'b1;
            w.ctl.ptr_inc = 1'b1;
            w.cond        = COND_SCAN_MORE;
            w.target      = STEP_NODE_SCAN;
         end
         STEP_NODE_DRAIN: begin
            w.cond = COND_NEVER;
         end
         STEP_UPDATE: begin
            w.ctl.upd = 1'b1;
         end
         STEP_WAIT_OUT: begin
            w.cond   = COND_OUT_BUSY;
            w.target = STEP_WAIT_OUT;
         end
         STEP_EMIT: begin
            w.ctl.emit = 1'b1;
            w.cond     = COND_MORE_JOBS;
            w.target   = STEP_JOB_INIT;
         end
         STEP_DONE: begin
            w.ctl.done = 1'b1;
            w.cond     = COND_ALWAYS;
            w.target   = STEP_LOAD;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_LOAD;
         end
      endcase
      return w;
   endfunction

endpackage

/* design/glls_seq.sv */
// ----------------------------------------------------------------------------
// glls_seq: microprogram sequencer
// Holds the step counter, reads the control store and resolves jumps.
// ----------------------------------------------------------------------------
module glls_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  glls_pkg::glls_stat_type stat,
   output glls_pkg::glls_ctl_type  ctl
);

   logic [glls_pkg::STEP_W-1:0] step_ff;
   logic [glls_pkg::STEP_W-1:0] step_in;
   glls_pkg::glls_uword_type    uword;
   logic                        jump;

   assign uword = glls_pkg::glls_ucode(step_ff);
   assign ctl   = uword.ctl;

   always_comb begin
      unique case (uword.cond)
         glls_pkg::COND_NEVER:     jump = 1'b0;
         glls_pkg::COND_ALWAYS:    jump = 1'b1;
         glls_pkg::COND_SCAN_MORE: jump = stat.scan_more;
         glls_pkg::COND_NOT_CLOSE: jump = !stat.close_acc;
         glls_pkg::COND_OUT_BUSY:  jump = stat.out_busy;
         glls_pkg::COND_MORE_JOBS: jump = stat.more_jobs;
         default:                  jump = 1'b1;
      endcase
      step_in = jump ? uword.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= glls_pkg::STEP_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

/* design/glls_dp.sv */
// ----------------------------------------------------------------------------
// glls_dp: scheduler datapath
// Weight and load memories, job taken bits, scan pointer, best-job and
// least-load registers, saturating load update and the result register.
// ----------------------------------------------------------------------------
module glls_dp #(
   parameter int MAX_BATCH = 64,
   parameter int N_NODES   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  glls_pkg::glls_ctl_type  ctl,
   output glls_pkg::glls_stat_type stat,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [31:0]             req_tdata,
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tlast,
   input  logic                    csr_we,
   input  logic [4:0]              csr_wdata
);

   localparam int JW    = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
   localparam int NW    = (N_NODES > 1) ? $clog2(N_NODES) : 1;
   localparam int PTR_W = (JW > NW) ? JW : NW;
   localparam int CNT_W = $clog2(MAX_BATCH + 1);
   localparam int OW    = (NW + 1 > 5) ? NW + 1 : 5;

   logic [30:0]          weight_mem_ff [MAX_BATCH];
   logic [47:0]          load_mem_ff   [N_NODES];
   logic [MAX_BATCH-1:0] taken_ff;

   logic [4:0]       active_ff, active_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] res_ff, res_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [PTR_W-1:0] limit_ff, limit_in;

   logic [30:0]      wdat_ff;
   logic             jvld_ff;
   logic [JW-1:0]    jidx_ff;
   logic [47:0]      ldat_ff;
   logic             nvld_ff;
   logic [NW-1:0]    nidx_ff;

   logic             found_ff, found_in;
   logic [30:0]      best_w_ff, best_w_in;
   logic [JW-1:0]    best_idx_ff, best_idx_in;
   logic [47:0]      best_load_ff, best_load_in;
   logic [NW-1:0]    lo_ff, lo_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [4:0]       rsp_node_ff, rsp_node_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             accept;
   logic             close;
   logic [PTR_W-1:0] nodes_m1;
   logic [48:0]      sum;
   logic [47:0]      sat_sum;
   logic [OW-1:0]    node_wide;
   logic [CNT_W-1:0] res_next;

   assign req_tready = ctl.accept;
   assign accept     = ctl.accept && req_tvalid;
   // A batch also closes when its last free slot is filled.
   assign close      = req_tlast || (count_ff == CNT_W'(MAX_BATCH - 1));
   assign res_next   = res_ff + CNT_W'(1);

   assign stat.scan_more = (ptr_ff != limit_ff);
   assign stat.close_acc = accept && close;
   assign stat.out_busy  = rsp_valid_ff && !rsp_tready;
   assign stat.more_jobs = (res_next != count_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_node_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Effective node count minus one: zero acts as one, large values clamp.
   always_comb begin
      if (32'(active_ff) > 32'(N_NODES)) begin
         nodes_m1 = PTR_W'(N_NODES - 1);
      end else if (active_ff == 5'd0) begin
         nodes_m1 = '0;
      end else begin
         nodes_m1 = PTR_W'(active_ff - 5'd1);
      end
   end

   assign sum       = {1'b0, best_load_ff} + 49'(best_w_ff);
   assign sat_sum   = sum[48] ? '1 : sum[47:0];
   assign node_wide = OW'(lo_ff) + OW'(1);

   always_comb begin
      active_in    = csr_we ? csr_wdata : active_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      ptr_in       = ptr_ff;
      limit_in     = limit_ff;
      found_in     = found_ff;
      best_w_in    = best_w_ff;
      best_idx_in  = best_idx_ff;
      best_load_in = best_load_ff;
      lo_in        = lo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_node_in  = rsp_node_ff;
      rsp_last_in  = rsp_last_ff;

      if (accept) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (ctl.done) begin
         count_in = '0;
         res_in   = '0;
      end

      if (ctl.ptr_clr) begin
         ptr_in = '0;
      end else if (ctl.ptr_inc) begin
         ptr_in = ptr_ff + PTR_W'(1);
      end
      if (ctl.lim_job) begin
         limit_in = PTR_W'(count_ff - CNT_W'(1));
      end else if (ctl.lim_node) begin
         limit_in = nodes_m1;
      end

      if (ctl.best_clr) begin
         found_in = 1'b0;
      end else if (jvld_ff && !taken_ff[jidx_ff] && (!found_ff || wdat_ff > best_w_ff)) begin
         found_in    = 1'b1;
         best_w_in   = wdat_ff;
         best_idx_in = jidx_ff;
      end

      // Strict compare keeps the lowest node on equal loads.
      if (nvld_ff && (nidx_ff == '0 || ldat_ff < best_load_ff)) begin
         best_load_in = ldat_ff;
         lo_in        = nidx_ff;
      end

      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_node_in  = node_wide[4:0];
         rsp_last_in  = !stat.more_jobs;
         res_in       = res_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 5'd16;
         count_ff     <= '0;
         res_ff       <= '0;
         ptr_ff       <= '0;
         limit_ff     <= PTR_W'(N_NODES - 1);
         found_ff     <= 1'b0;
         jvld_ff      <= 1'b0;
         nvld_ff      <= 1'b0;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         count_ff     <= count_in;
         res_ff       <= res_in;
         ptr_ff       <= ptr_in;
         limit_ff     <= limit_in;
         found_ff     <= found_in;
         jvld_ff      <= ctl.rd_job;
         nvld_ff      <= ctl.rd_node;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            taken_ff[count_ff[JW-1:0]] <= 1'b0;
         end
         if (ctl.mark) begin
            taken_ff[best_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      best_w_ff    <= best_w_in;
      best_idx_ff  <= best_idx_in;
      best_load_ff <= best_load_in;
      lo_ff        <= lo_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_last_ff  <= rsp_last_in;
      jidx_ff      <= ptr_ff[JW-1:0];
      nidx_ff      <= ptr_ff[NW-1:0];
   end

   // Weight memory: one write on accept, one registered read during the job scan.
   always_ff @(posedge clock) begin
      if (accept) begin
         weight_mem_ff[count_ff[JW-1:0]] <= req_tdata[30:0];
      end
      wdat_ff <= weight_mem_ff[ptr_ff[JW-1:0]];
   end

   // Load memory: cleared by the pass after reset, updated once per assignment.
   always_ff @(posedge clock) begin
      if (ctl.clear_wr) begin
         load_mem_ff[ptr_ff[NW-1:0]] <= '0;
      end else if (ctl.upd) begin
         load_mem_ff[lo_ff] <= sat_sum;
      end
      ldat_ff <= load_mem_ff[ptr_ff[NW-1:0]];
   end

endmodule

/* design/greedy_least_loaded_batch_scheduler.sv */
// Loading accepts one word per cycle; the batch closes on the word marked
// last or when the store is full. Each assignment runs sequential scans over
// the weight and load memories and may wait on a stalled output; a final
// step ends the batch. Reset is synchronous; after reset a clearing pass
// zeroes the load memory before the first word is accepted.
// ----------------------------------------------------------------------------
// greedy_least_loaded_batch_scheduler: heaviest job to least-loaded node
// Collects a batch of job weights and assigns each, heaviest first, to the
// active node with the smallest running load, emitting one node number per job.
// ----------------------------------------------------------------------------
module greedy_least_loaded_batch_scheduler #(
   parameter int MAX_BATCH = 64,
   parameter int N_NODES   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] job_weight, [31] zero
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [4:0] node_number, [7:5] zero
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);

   glls_pkg::glls_ctl_type  ctl;
   glls_pkg::glls_stat_type stat;

   glls_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   glls_dp #(
      .MAX_BATCH (MAX_BATCH),
      .N_NODES   (N_NODES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .stat       (stat),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for greedy_least_loaded_batch_scheduler
// Streams batches of job weights into the scheduler and checks every node
// number and last flag it returns against a behavioral scheduler kept in the
// bench. A directed table comes first, followed by random batches under
// several node counts and one long output stall.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          MAX_JOBS  = 64;
   localparam int          N_NODES   = 16;
   localparam logic [47:0] LOAD_MAX  = 48'hFFFF_FFFF_FFFF;
   localparam int          SETTLE    = 16;
   localparam int          LONG_HOLD = 300;
   localparam int unsigned LIMIT     = 200_000;

   typedef struct packed {
      logic [4:0] node;
      logic       last;
   } sched_word_type;

   // One row of the directed table. A node of zero means that the expected
   // value comes from the scheduler model.
   typedef struct packed {
      logic        set_cfg;
      logic [4:0]  cfg;
      logic [30:0] weight;
      logic        last;
      logic [4:0]  node;
   } dir_row_type;

   localparam dir_row_type DIR_ROWS [20] = '{
      '{1'b0, 5'd0,  31'h7FFF_FFFF, 1'b1, 5'd1},
      '{1'b0, 5'd0,  31'h0000_0000, 1'b1, 5'd2},
      '{1'b0, 5'd0,  31'h0000_0000, 1'b1, 5'd2},
      '{1'b0, 5'd0,  31'h0000_0003, 1'b0, 5'd0},
      '{1'b0, 5'd0,  31'h0000_0003, 1'b0, 5'd0},
      '{1'b0, 5'd0,  31'h0000_0003, 1'b0, 5'd0},
      '{1'b0, 5'd0,  31'h0000_0003, 1'b1, 5'd5},
      '{1'b0, 5'd0,  31'h0000_0001, 1'b0, 5'd0},
      '{1'b0, 5'd0,  31'h5555_5555, 1'b0, 5'd0},
      '{1'b0, 5'd0,  31'h2AAA_AAAA, 1'b1, 5'd0},
      '{1'b0, 5'd0,  31'h4000_0000, 1'b0, 5'd0},
      '{1'b0, 5'd0,  31'h4000_0000, 1'b0, 5'd0},
      '{1'b0, 5'd0,  31'h0000_0007, 1'b1, 5'd0},
      '{1'b1, 5'd0,  31'h0000_0009, 1'b1, 5'd1},
      '{1'b1, 5'd1,  31'h0000_0000, 1'b1, 5'd1},
      '{1'b1, 5'd31, 31'h0000_0005, 1'b1, 5'd0},
      '{1'b1, 5'd16, 31'h7FFF_FFFF, 1'b1, 5'd0},
      '{1'b1, 5'd17, 31'h0000_0001, 1'b1, 5'd0},
      '{1'b1, 5'd2,  31'h0000_0000, 1'b0, 5'd0},
      '{1'b0, 5'd0,  31'h0000_0000, 1'b1, 5'd0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [30:0] job_weight, [31] zero
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [4:0] node_number, [7:5] zero
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [4:0]  csr_wdata  = '0;

   // Scheduler model state.
   logic [47:0]    load_tab [N_NODES];
   logic [30:0]    job_buf [MAX_JOBS];
   int unsigned    job_cnt   = 0;
   logic [4:0]     nodes_reg = 5'd16;
   sched_word_type sched_q [$];

   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;
   bit          idling      = 1'b1;
   int unsigned hold_asks   = 0;
   int unsigned hold_seen   = 0;
   int unsigned hold_left   = 0;
   int unsigned gap_left    = 0;

   greedy_least_loaded_batch_scheduler DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Stores one job; on a closing job, assigns the whole batch heaviest first
   // and queues one node number per job.
   function automatic void predict_job(logic [30:0] w, logic close);
      int unsigned    n_act;
      int unsigned    best;
      int unsigned    lo;
      bit             found;
      bit             done_job [MAX_JOBS];
      logic [48:0]    sum;
      sched_word_type word_out;
      job_buf[job_cnt] = w;
      job_cnt++;
      if (job_cnt == MAX_JOBS) close = 1'b1;
      if (!close) return;
      n_act = (nodes_reg == 0) ? 1 : (nodes_reg > N_NODES) ? N_NODES : nodes_reg;
      foreach (done_job[k]) done_job[k] = 1'b0;
      for (int r = 0; r < job_cnt; r++) begin
         found = 1'b0;
         best  = 0;
         for (int k = 0; k < job_cnt; k++) begin
            if (!done_job[k] && (!found || job_buf[k] > job_buf[best])) begin
               best  = k;
               found = 1'b1;
            end
         end
         done_job[best] = 1'b1;
         lo = 0;
         for (int k = 1; k < n_act; k++) begin
            if (load_tab[k] < load_tab[lo]) lo = k;
         end
         sum          = load_tab[lo] + job_buf[best];
         load_tab[lo] = (sum > LOAD_MAX) ? LOAD_MAX : sum[47:0];
         word_out.node = 5'(lo + 1);
         word_out.last = (r == job_cnt - 1);
         sched_q.push_back(word_out);
      end
      job_cnt = 0;
   endfunction

   function automatic void check_result(logic [4:0] node, logic last);
      sched_word_type want;
      if (sched_q.size() == 0) begin
         fail_count++;
         $error("node_number: expected none, got %0d", node);
         return;
      end
      want = sched_q.pop_front();
      if (node !== want.node) begin
         fail_count++;
         $error("node_number: expected %0d, got %0d", want.node, node);
      end
      if (last !== want.last) begin
         fail_count++;
         $error("last_of_batch: expected %0d, got %0d", want.last, last);
      end
   endfunction

   function automatic logic [30:0] pick_weight();
      case ($urandom_range(0, 5))
         0: return 31'h0;
         1: return 31'h7FFF_FFFF;
         2: return 31'($urandom_range(0, 3));
         3: return 31'($urandom_range(0, 255));
         default: return 31'($urandom);
      endcase
   endfunction

   task automatic send_job(input logic [30:0] w, input logic close);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, w};
      req_tlast  <= close;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_job(w, close);
   endtask

   // Waits until every queued result has come back, then lets the block settle.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (sched_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_nodes(input logic [4:0] v);
      wait_drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      nodes_reg = v;
   endtask

   // Output side: random stalls, plus one long hold-off when asked for.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result(rsp_tdata[4:0], rsp_tlast);
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
         hold_seen  <= hold_asks;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (gap_left != 0) begin
         gap_left   <= gap_left - 1;
         rsp_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
         gap_left   <= $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("cycle limit reached with %0d words outstanding", sched_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned sent;
      int unsigned len;
      bit          shut;
      foreach (load_tab[k]) load_tab[k] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_ROWS[i]) begin
         if (DIR_ROWS[i].set_cfg) set_nodes(DIR_ROWS[i].cfg);
         send_job(DIR_ROWS[i].weight, DIR_ROWS[i].last);
         if (DIR_ROWS[i].node != 0) sched_q[sched_q.size() - 1].node = DIR_ROWS[i].node;
      end

      for (int ph = 0; ph < 7; ph++) begin
         set_nodes((ph == 1) ? 5'd16 : 5'($urandom_range(0, 31)));
         idling <= (ph < 6) && ($urandom_range(0, 3) != 0);
         if (ph == 1) hold_asks <= hold_asks + 1;
         sent = 0;
         while (sent < 12) begin
            if (ph == 2) begin
               // A full batch; without the last flag the store closes it.
               len  = MAX_JOBS;
               shut = $urandom_range(0, 1);
            end else begin
               len  = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20)
                                                  : $urandom_range(1, 6);
               shut = 1'b1;
            end
            for (int j = 0; j < len; j++) send_job(pick_weight(), shut && (j == len - 1));
            sent += len;
         end
      end

      wait_drain();
      repeat (4 * SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
